// ===== sv/pbg_pkg.sv =====
// Shared constants, types and term tables for the polynomial basis generator.
package pbg_pkg;

   localparam int MAX_TERMS  = 20;
   localparam int COORD_BITS = 16;
   localparam int COORD_FRAC = 13;
   localparam int OUT_BITS   = 48;
   localparam int IDX_W      = 5;
   localparam int COEF_W     = 3;

   // A factor must hold a coordinate and the fixed-point one (2^COORD_FRAC)
   localparam int FACT_W   = (COORD_BITS > COORD_FRAC + 2) ? COORD_BITS : COORD_FRAC + 2;
   localparam int PROD2_W  = 2 * FACT_W;
   localparam int PROD3_W  = 3 * FACT_W;
   localparam int SCALED_W = PROD3_W + COEF_W + 1;

   // Stream payload widths, rounded up to whole bytes
   localparam int REQ_W  = ((3 * COORD_BITS + 7) / 8) * 8;
   localparam int REQ_UW = 4;
   localparam int RSP_W  = ((IDX_W + OUT_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      CMD_VALUE = 2'd0,
      CMD_GRAD  = 2'd1,
      CMD_HESS  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic       CFG_DEGREE = 1'b0;
   localparam logic       CFG_DIMS   = 1'b1;
   localparam logic [1:0] DIMS_3D    = 2'd3;

   // Exponents of one monomial: [0] x, [1] y, [2] z
   typedef logic [2:0][1:0] expv_type;

   // Tag that travels with each term through the pipeline
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
      logic             last;
   } term_tag_type;

   function automatic expv_type mk_exp(input logic [1:0] ex, input logic [1:0] ey,
                                       input logic [1:0] ez);
      expv_type e;
      e[0] = ex;
      e[1] = ey;
      e[2] = ez;
      return e;
   endfunction

   // Exponents of term idx in basis order
   function automatic expv_type term_exps(input logic is3d, input logic [IDX_W-1:0] idx);
      expv_type e;
      e = mk_exp(2'd0, 2'd0, 2'd0);
      if (is3d) begin
         case (idx)
            5'd1:    e = mk_exp(2'd1, 2'd0, 2'd0);
            5'd2:    e = mk_exp(2'd0, 2'd1, 2'd0);
            5'd3:    e = mk_exp(2'd0, 2'd0, 2'd1);
            5'd4:    e = mk_exp(2'd2, 2'd0, 2'd0);
            5'd5:    e = mk_exp(2'd0, 2'd2, 2'd0);
            5'd6:    e = mk_exp(2'd0, 2'd0, 2'd2);
            5'd7:    e = mk_exp(2'd1, 2'd1, 2'd0);
            5'd8:    e = mk_exp(2'd0, 2'd1, 2'd1);
            5'd9:    e = mk_exp(2'd1, 2'd0, 2'd1);
            5'd10:   e = mk_exp(2'd2, 2'd1, 2'd0);
            5'd11:   e = mk_exp(2'd2, 2'd0, 2'd1);
            5'd12:   e = mk_exp(2'd1, 2'd2, 2'd0);
            5'd13:   e = mk_exp(2'd0, 2'd2, 2'd1);
            5'd14:   e = mk_exp(2'd1, 2'd0, 2'd2);
            5'd15:   e = mk_exp(2'd0, 2'd1, 2'd2);
            5'd16:   e = mk_exp(2'd1, 2'd1, 2'd1);
            5'd17:   e = mk_exp(2'd3, 2'd0, 2'd0);
            5'd18:   e = mk_exp(2'd0, 2'd3, 2'd0);
            5'd19:   e = mk_exp(2'd0, 2'd0, 2'd3);
            default: e = mk_exp(2'd0, 2'd0, 2'd0);
         endcase
      end else begin
         case (idx)
            5'd1:    e = mk_exp(2'd1, 2'd0, 2'd0);
            5'd2:    e = mk_exp(2'd0, 2'd1, 2'd0);
            5'd3:    e = mk_exp(2'd2, 2'd0, 2'd0);
            5'd4:    e = mk_exp(2'd0, 2'd2, 2'd0);
            5'd5:    e = mk_exp(2'd1, 2'd1, 2'd0);
            5'd6:    e = mk_exp(2'd1, 2'd2, 2'd0);
            5'd7:    e = mk_exp(2'd2, 2'd1, 2'd0);
            5'd8:    e = mk_exp(2'd3, 2'd0, 2'd0);
            5'd9:    e = mk_exp(2'd0, 2'd3, 2'd0);
            default: e = mk_exp(2'd0, 2'd0, 2'd0);
         endcase
      end
      return e;
   endfunction

   // Number of terms for a degree, clipped to the term limit
   function automatic logic [IDX_W-1:0] term_count(input logic is3d, input logic [1:0] degree);
      logic [IDX_W-1:0] n;
      n = 5'd1;
      unique case (degree)
         2'd0: n = 5'd1;
         2'd1: n = is3d ? 5'd4 : 5'd3;
         2'd2: n = is3d ? 5'd10 : 5'd6;
         2'd3: n = is3d ? 5'd20 : 5'd10;
      endcase
      if (n > IDX_W'(MAX_TERMS)) begin
         n = IDX_W'(MAX_TERMS);
      end
      return n;
   endfunction

endpackage

// ===== sv/pbg_seq.sv =====
// Item holder, term sequencer and term decode stage (exponents, coefficient, factors).
module pbg_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [pbg_pkg::REQ_W-1:0]              req_tdata,
   input  logic [pbg_pkg::REQ_UW-1:0]             req_tuser,
   input  logic [1:0]                             basis_degree,
   input  logic                                   is3d,
   output pbg_pkg::term_tag_type                  s1_tag,
   output logic signed [pbg_pkg::FACT_W-1:0]      s1_f0,
   output logic signed [pbg_pkg::FACT_W-1:0]      s1_f1,
   output logic signed [pbg_pkg::FACT_W-1:0]      s1_f2,
   output logic [pbg_pkg::COEF_W-1:0]             s1_coef
);

   localparam int CB = pbg_pkg::COORD_BITS;
   localparam int FW = pbg_pkg::FACT_W;
   localparam int IW = pbg_pkg::IDX_W;
   localparam logic signed [FW-1:0] FACT_ONE = FW'(1 << pbg_pkg::COORD_FRAC);
   localparam logic [1:0] AXIS_SEL_X = pbg_pkg::AXIS_X;
   localparam logic [1:0] AXIS_SEL_Y = pbg_pkg::AXIS_Y;

   // Held item
   logic                    busy_ff;
   logic [1:0]              cmd_ff;
   logic [1:0]              axis_ff;
   logic signed [CB-1:0]    px_ff, py_ff, pz_ff;
   logic                    is3d_ff;
   logic [IW-1:0]           n_ff;
   logic [IW-1:0]           t_ff;

   logic                    last_now;
   logic                    accept;

   // Stage 1 registers
   pbg_pkg::term_tag_type   tag_ff, tag_in;
   logic signed [FW-1:0]    f0_ff, f1_ff, f2_ff;
   logic signed [FW-1:0]    f_in [3];
   logic [pbg_pkg::COEF_W-1:0] coef_ff, coef_in;

   assign last_now   = (t_ff == n_ff - IW'(1));
   assign req_tready = adv && (!busy_ff || last_now);
   assign accept     = req_tvalid && req_tready;

   // Load a new item or step through the terms of the held one
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         t_ff    <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         t_ff    <= '0;
      end else if (busy_ff && adv) begin
         if (last_now) begin
            busy_ff <= 1'b0;
         end else begin
            t_ff <= t_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_tuser[1:0];
         axis_ff <= req_tuser[3:2];
         px_ff   <= req_tdata[CB-1:0];
         py_ff   <= req_tdata[2*CB-1:CB];
         pz_ff   <= is3d ? req_tdata[3*CB-1:2*CB] : '0;
         is3d_ff <= is3d;
         n_ff    <= pbg_pkg::term_count(is3d, basis_degree);
      end
   end

   // Decode the current term: apply the derivative, then list its factors
   always_comb begin
      pbg_pkg::expv_type ex;
      logic [1:0] ea;
      logic       zero;
      logic [2:0] sxy;
      logic [2:0] sall;
      ex      = pbg_pkg::term_exps(is3d_ff, t_ff);
      zero    = 1'b0;
      coef_in = pbg_pkg::COEF_W'(1);
      unique case (axis_ff)
         AXIS_SEL_X: ea = ex[0];
         AXIS_SEL_Y: ea = ex[1];
         default:    ea = ex[2];
      endcase
      unique case (pbg_pkg::cmd_type'(cmd_ff))
         pbg_pkg::CMD_VALUE: begin
            coef_in = pbg_pkg::COEF_W'(1);
         end
         pbg_pkg::CMD_GRAD: begin
            zero    = (axis_ff > pbg_pkg::AXIS_Z) || (ea == 2'd0);
            coef_in = pbg_pkg::COEF_W'(ea);
            ea      = ea - 2'd1;
         end
         pbg_pkg::CMD_HESS: begin
            zero    = (axis_ff > pbg_pkg::AXIS_Z) || (ea < 2'd2);
            coef_in = (ea == 2'd3) ? pbg_pkg::COEF_W'(6) : pbg_pkg::COEF_W'(2);
            ea      = ea - 2'd2;
         end
         pbg_pkg::CMD_NONE: begin
            zero = 1'b1;
         end
      endcase
      unique case (axis_ff)
         AXIS_SEL_X: ex[0] = ea;
         AXIS_SEL_Y: ex[1] = ea;
         default:    ex[2] = ea;
      endcase
      if (zero) begin
         coef_in = '0;
      end
      sxy  = {1'b0, ex[0]} + {1'b0, ex[1]};
      sall = sxy + {1'b0, ex[2]};
      for (int k = 0; k < 3; k++) begin
         if (3'(k) < {1'b0, ex[0]}) begin
            f_in[k] = FW'(px_ff);
         end else if (3'(k) < sxy) begin
            f_in[k] = FW'(py_ff);
         end else if (3'(k) < sall) begin
            f_in[k] = FW'(pz_ff);
         end else begin
            f_in[k] = FACT_ONE;
         end
      end
      tag_in.valid = busy_ff;
      tag_in.index = t_ff;
      tag_in.last  = last_now;
   end

   // Advance stage 1; only the valid bit is reset
   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff.index <= tag_in.index;
         tag_ff.last  <= tag_in.last;
         f0_ff        <= f_in[0];
         f1_ff        <= f_in[1];
         f2_ff        <= f_in[2];
         coef_ff      <= coef_in;
      end
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (adv) begin
         tag_ff.valid <= tag_in.valid;
      end
   end

   assign s1_tag  = tag_ff;
   assign s1_f0   = f0_ff;
   assign s1_f1   = f1_ff;
   assign s1_f2   = f2_ff;
   assign s1_coef = coef_ff;

endmodule

// ===== sv/pbg_mul.sv =====
// Product stages: two factor multiplies, coefficient scaling and output saturation.
module pbg_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  pbg_pkg::term_tag_type                  s1_tag,
   input  logic signed [pbg_pkg::FACT_W-1:0]      s1_f0,
   input  logic signed [pbg_pkg::FACT_W-1:0]      s1_f1,
   input  logic signed [pbg_pkg::FACT_W-1:0]      s1_f2,
   input  logic [pbg_pkg::COEF_W-1:0]             s1_coef,
   output pbg_pkg::term_tag_type                  out_tag,
   output logic signed [pbg_pkg::OUT_BITS-1:0]    out_value
);

   localparam int FW = pbg_pkg::FACT_W;
   localparam int P2 = pbg_pkg::PROD2_W;
   localparam int P3 = pbg_pkg::PROD3_W;
   localparam int SW = pbg_pkg::SCALED_W;
   localparam int OB = pbg_pkg::OUT_BITS;
   localparam int CW = pbg_pkg::COEF_W;

   pbg_pkg::term_tag_type tag2_ff, tag3_ff, tag4_ff;
   logic signed [P2-1:0]  p_ff, p_in;
   logic signed [FW-1:0]  f2_ff;
   logic [CW-1:0]         coef2_ff, coef3_ff;
   logic signed [P3-1:0]  q_ff, q_in;
   logic signed [SW-1:0]  v_in;
   logic signed [OB-1:0]  val_ff, val_in;

   assign p_in = s1_f0 * s1_f1;
   assign q_in = p_ff * f2_ff;
   assign v_in = q_ff * $signed({1'b0, coef3_ff});

   // Clamp the scaled term to the signed output range
   always_comb begin
      logic hi_ovf;
      logic lo_ovf;
      hi_ovf = !v_in[SW-1] && (|v_in[SW-2:OB-1]);
      lo_ovf = v_in[SW-1] && !(&v_in[SW-2:OB-1]);
      if (hi_ovf) begin
         val_in = {1'b0, {(OB-1){1'b1}}};
      end else if (lo_ovf) begin
         val_in = {1'b1, {(OB-1){1'b0}}};
      end else begin
         val_in = v_in[OB-1:0];
      end
   end

   // Advance stages 2 to 4; only the valid bits are reset
   always_ff @(posedge clock) begin
      if (adv) begin
         tag2_ff.index <= s1_tag.index;
         tag2_ff.last  <= s1_tag.last;
         p_ff          <= p_in;
         f2_ff         <= s1_f2;
         coef2_ff      <= s1_coef;
         tag3_ff.index <= tag2_ff.index;
         tag3_ff.last  <= tag2_ff.last;
         q_ff          <= q_in;
         coef3_ff      <= coef2_ff;
         tag4_ff.index <= tag3_ff.index;
         tag4_ff.last  <= tag3_ff.last;
         val_ff        <= val_in;
      end
      if (reset) begin
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
      end else if (adv) begin
         tag2_ff.valid <= s1_tag.valid;
         tag3_ff.valid <= tag2_ff.valid;
         tag4_ff.valid <= tag3_ff.valid;
      end
   end

   assign out_tag   = tag4_ff;
   assign out_value = val_ff;

endmodule

// ===== sv/polynomial_basis_and_gradient_gen.sv =====
// Top level of the monomial basis and derivative generator.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_tvalid/tready  | tdata pos_x,pos_y,pos_z; tuser command,axis_sel
//   rsp     | out       | rsp_tvalid/tready  | tdata term_index,term_value; tlast last_term
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// One term leaves per cycle while rsp is not stalled, and an item yields as many terms as its
// basis has (1 to 20); the term sequencer sets that count. Each term passes through four
// register stages (decode, two multiplies, scale and clamp). Reset clears the valid bits and
// loads degree 1 and three dimensions. A stall on rsp holds every stage in place and holds
// off req until the waiting result is taken.
module polynomial_basis_and_gradient_gen (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pbg_pkg::REQ_W-1:0]       req_tdata,   // pos_x, pos_y, pos_z
   input  logic [pbg_pkg::REQ_UW-1:0]      req_tuser,   // command, axis_sel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pbg_pkg::RSP_W-1:0]       rsp_tdata,   // term_index, term_value, zero pad
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [1:0]                      csr_wdata
);

   logic [1:0]  basis_degree_ff;
   logic [1:0]  space_dims_ff;
   logic        adv;

   pbg_pkg::term_tag_type                 s1_tag, out_tag;
   logic signed [pbg_pkg::FACT_W-1:0]     s1_f0, s1_f1, s1_f2;
   logic [pbg_pkg::COEF_W-1:0]            s1_coef;
   logic signed [pbg_pkg::OUT_BITS-1:0]   out_value;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         basis_degree_ff <= 2'd1;
         space_dims_ff   <= pbg_pkg::DIMS_3D;
      end else if (csr_we) begin
         unique case (csr_index)
            pbg_pkg::CFG_DEGREE: basis_degree_ff <= csr_wdata;
            pbg_pkg::CFG_DIMS:   space_dims_ff   <= csr_wdata;
         endcase
      end
   end

   // Move the whole pipeline when the output register is free or being taken
   assign adv = !out_tag.valid || rsp_tready;

   pbg_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .basis_degree (basis_degree_ff),
      .is3d         (space_dims_ff == pbg_pkg::DIMS_3D),
      .s1_tag       (s1_tag),
      .s1_f0        (s1_f0),
      .s1_f1        (s1_f1),
      .s1_f2        (s1_f2),
      .s1_coef      (s1_coef)
   );

   pbg_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .s1_tag    (s1_tag),
      .s1_f0     (s1_f0),
      .s1_f1     (s1_f1),
      .s1_f2     (s1_f2),
      .s1_coef   (s1_coef),
      .out_tag   (out_tag),
      .out_value (out_value)
   );

   assign rsp_tvalid = out_tag.valid;
   assign rsp_tlast  = out_tag.last;
   assign rsp_tdata  = pbg_pkg::RSP_W'({out_value, out_tag.index});

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the monomial basis and derivative generator.
module testbench;

   localparam int CLK_HALF     = 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 17;
   localparam int DRAIN_CYCLES = 8;
   localparam int DIR_ROWS     = 25;

   localparam int COORD_BITS = pbg_pkg::COORD_BITS;
   localparam int COORD_FRAC = pbg_pkg::COORD_FRAC;
   localparam int OUT_BITS   = pbg_pkg::OUT_BITS;
   localparam int IDX_W      = pbg_pkg::IDX_W;
   localparam int MAX_TERMS  = pbg_pkg::MAX_TERMS;
   localparam int REQ_W      = pbg_pkg::REQ_W;
   localparam int REQ_UW     = pbg_pkg::REQ_UW;
   localparam int RSP_W      = pbg_pkg::RSP_W;

   localparam logic [1:0] AXIS_X     = pbg_pkg::AXIS_X;
   localparam logic [1:0] AXIS_Y     = pbg_pkg::AXIS_Y;
   localparam logic [1:0] AXIS_Z     = pbg_pkg::AXIS_Z;
   localparam logic       CFG_DEGREE = pbg_pkg::CFG_DEGREE;
   localparam logic       CFG_DIMS   = pbg_pkg::CFG_DIMS;
   localparam logic [1:0] DIMS_3D    = pbg_pkg::DIMS_3D;

   localparam pbg_pkg::cmd_type CMD_VALUE = pbg_pkg::CMD_VALUE;
   localparam pbg_pkg::cmd_type CMD_GRAD  = pbg_pkg::CMD_GRAD;
   localparam pbg_pkg::cmd_type CMD_HESS  = pbg_pkg::CMD_HESS;
   localparam pbg_pkg::cmd_type CMD_NONE  = pbg_pkg::CMD_NONE;

   localparam logic [1:0] AXIS_NONE = 2'd3;
   localparam logic [COORD_BITS-1:0] POS_MAX = 16'h7FFF;
   localparam logic [COORD_BITS-1:0] POS_MIN = 16'h8000;
   localparam logic [COORD_BITS-1:0] POS_ONE = 16'h2000;
   localparam logic [COORD_BITS-1:0] POS_ODD = 16'h1234;
   localparam logic [COORD_BITS-1:0] POS_NEG = 16'hFFFF;
   localparam logic [COORD_BITS-1:0] POS_ZERO = 16'h0000;

   // How a row's expected terms are produced
   typedef enum logic [1:0] {
      CHK_PREDICT,   // computed by the predictor
      CHK_ZERO,      // every term is zero
      CHK_UNIT       // constant term is 1.0, all others zero
   } check_kind_type;

   typedef struct packed {
      logic [1:0]            degree;
      logic [1:0]            dims;
      pbg_pkg::cmd_type      cmd;
      logic [1:0]            axis;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      check_kind_type        chk;
   } stim_row_type;

   typedef struct packed {
      logic [IDX_W-1:0]    index;
      logic [OUT_BITS-1:0] value;
      logic                last;
   } basis_term_type;

   // Directed rows: reset state, extremes, every command and the zero cases
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{2'd1, DIMS_3D, CMD_VALUE, AXIS_X,    POS_ZERO, POS_ZERO, POS_ZERO, CHK_UNIT},
      '{2'd1, DIMS_3D, CMD_GRAD,  AXIS_X,    POS_MAX,  POS_MIN,  POS_MAX,  CHK_PREDICT},
      '{2'd0, DIMS_3D, CMD_VALUE, AXIS_NONE, POS_ODD,  POS_MIN,  POS_MAX,  CHK_UNIT},
      '{2'd0, DIMS_3D, CMD_GRAD,  AXIS_X,    POS_MAX,  POS_MAX,  POS_MAX,  CHK_ZERO},
      '{2'd3, DIMS_3D, CMD_VALUE, AXIS_X,    POS_MAX,  POS_MAX,  POS_MAX,  CHK_PREDICT},
      '{2'd3, DIMS_3D, CMD_VALUE, AXIS_X,    POS_MIN,  POS_MIN,  POS_MIN,  CHK_PREDICT},
      '{2'd3, DIMS_3D, CMD_VALUE, AXIS_Y,    POS_MIN,  POS_MAX,  POS_MIN,  CHK_PREDICT},
      '{2'd3, DIMS_3D, CMD_GRAD,  AXIS_X,    POS_MIN,  POS_MAX,  POS_MIN,  CHK_PREDICT},
      '{2'd3, DIMS_3D, CMD_GRAD,  AXIS_Y,    POS_MIN,  POS_MAX,  POS_MIN,  CHK_PREDICT},
      '{2'd3, DIMS_3D, CMD_GRAD,  AXIS_Z,    POS_MIN,  POS_MAX,  POS_MIN,  CHK_PREDICT},
      '{2'd3, DIMS_3D, CMD_HESS,  AXIS_X,    POS_MIN,  POS_MIN,  POS_MIN,  CHK_PREDICT},
      '{2'd3, DIMS_3D, CMD_HESS,  AXIS_Y,    POS_MIN,  POS_MIN,  POS_MIN,  CHK_PREDICT},
      '{2'd3, DIMS_3D, CMD_HESS,  AXIS_Z,    POS_MAX,  POS_MAX,  POS_MAX,  CHK_PREDICT},
      '{2'd3, DIMS_3D, CMD_NONE,  AXIS_X,    POS_MAX,  POS_MAX,  POS_MAX,  CHK_ZERO},
      '{2'd3, DIMS_3D, CMD_GRAD,  AXIS_NONE, POS_MAX,  POS_MIN,  POS_MAX,  CHK_ZERO},
      '{2'd3, DIMS_3D, CMD_HESS,  AXIS_NONE, POS_MIN,  POS_MAX,  POS_MIN,  CHK_ZERO},
      '{2'd3, 2'd2,    CMD_VALUE, AXIS_X,    POS_ODD,  POS_NEG,  POS_MAX,  CHK_PREDICT},
      '{2'd3, 2'd2,    CMD_VALUE, AXIS_X,    POS_ODD,  POS_NEG,  POS_MIN,  CHK_PREDICT},
      '{2'd3, 2'd2,    CMD_GRAD,  AXIS_Z,    POS_MAX,  POS_MAX,  POS_MAX,  CHK_ZERO},
      '{2'd3, 2'd2,    CMD_HESS,  AXIS_Z,    POS_MIN,  POS_MIN,  POS_MIN,  CHK_ZERO},
      '{2'd3, 2'd2,    CMD_GRAD,  AXIS_Y,    POS_MIN,  POS_MIN,  POS_ZERO, CHK_PREDICT},
      '{2'd3, 2'd2,    CMD_HESS,  AXIS_X,    POS_MAX,  POS_MIN,  POS_ODD,  CHK_PREDICT},
      '{2'd2, 2'd2,    CMD_GRAD,  AXIS_X,    POS_ONE,  POS_ONE,  POS_ONE,  CHK_PREDICT},
      '{2'd2, 2'd0,    CMD_HESS,  AXIS_Y,    POS_NEG,  POS_MIN,  POS_MAX,  CHK_PREDICT},
      '{2'd1, 2'd1,    CMD_VALUE, AXIS_Z,    POS_MIN,  POS_MAX,  POS_MAX,  CHK_PREDICT}
   };

   // Exponents per term as decimal digits x,y,z
   int solid_exp  [20] = '{0, 100, 10, 1, 200, 20, 2, 110, 11, 101,
                           210, 201, 120, 21, 102, 12, 111, 300, 30, 3};
   int planar_exp [10] = '{0, 100, 10, 200, 20, 110, 120, 210, 300, 30};
   int solid_count  [4] = '{1, 4, 10, 20};
   int planar_count [4] = '{1, 3, 6, 10};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;   // pos_x, pos_y, pos_z
   logic [REQ_UW-1:0]   req_tuser = '0;   // command, axis_sel
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [RSP_W-1:0]    rsp_tdata;        // term_index, term_value, zero pad
   logic                rsp_tlast;
   logic                csr_we = 1'b0;
   logic                csr_index = CFG_DEGREE;
   logic [1:0]          csr_wdata = 2'd0;

   basis_term_type  expected_terms [$];
   logic [1:0]      model_degree = 2'd1;
   logic [1:0]      model_dims   = DIMS_3D;
   logic [1:0]      cur_degree   = 2'd1;
   logic [1:0]      cur_dims     = DIMS_3D;
   check_kind_type  item_check   = CHK_PREDICT;
   bit              gaps_on      = 1'b1;
   int              stall_left   = 0;
   int              errors       = 0;
   int              cycle_count  = 0;

   polynomial_basis_and_gradient_gen u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // Value, slope or curvature of one monomial, saturated to the output width
   function automatic longint monomial_term(input int code, input pbg_pkg::cmd_type cmd,
                                            input logic [1:0] axis, input longint px,
                                            input longint py, input longint pz);
      int     ex [3];
      longint pos [3];
      longint coef;
      longint mono;
      longint lim;
      int     steps;
      int     order;
      int     i;
      int     k;
      ex[0]  = code / 100;
      ex[1]  = (code / 10) % 10;
      ex[2]  = code % 10;
      pos[0] = px;
      pos[1] = py;
      pos[2] = pz;
      coef   = 1;
      mono   = 1;
      if (cmd == CMD_NONE) begin
         return 0;
      end
      if (cmd != CMD_VALUE) begin
         if (axis == AXIS_NONE) begin
            return 0;
         end
         steps = (cmd == CMD_HESS) ? 2 : 1;
         for (k = 0; k < steps; k++) begin
            if (ex[axis] == 0) begin
               return 0;
            end
            coef = coef * ex[axis];
            ex[axis] = ex[axis] - 1;
         end
      end
      order = ex[0] + ex[1] + ex[2];
      for (i = 0; i < 3; i++) begin
         for (k = 0; k < ex[i]; k++) begin
            mono = mono * pos[i];
         end
      end
      // Bring lower orders up to the cubic scale of 39 fraction bits
      mono = mono * (longint'(1) << (COORD_FRAC * (3 - order)));
      mono = mono * coef;
      lim  = (longint'(1) << (OUT_BITS - 1)) - 1;
      if (mono > lim) begin
         mono = lim;
      end else if (mono < -lim - 1) begin
         mono = -lim - 1;
      end
      return mono;
   endfunction

   // Queue every term that one item yields under the current settings
   function automatic void queue_basis(input pbg_pkg::cmd_type cmd, input logic [1:0] axis,
                                       input logic signed [COORD_BITS-1:0] x,
                                       input logic signed [COORD_BITS-1:0] y,
                                       input logic signed [COORD_BITS-1:0] z,
                                       input check_kind_type chk);
      bit             solid;
      int             n;
      int             i;
      longint         v;
      basis_term_type t;
      solid = (model_dims == DIMS_3D);
      n = solid ? solid_count[model_degree] : planar_count[model_degree];
      if (n > MAX_TERMS) begin
         n = MAX_TERMS;
      end
      for (i = 0; i < n; i++) begin
         case (chk)
            CHK_ZERO: v = 0;
            CHK_UNIT: v = (i == 0) ? (longint'(1) << (3 * COORD_FRAC)) : 0;
            default: begin
               v = monomial_term(solid ? solid_exp[i] : planar_exp[i], cmd, axis,
                                 longint'(x), longint'(y), solid ? longint'(z) : 0);
            end
         endcase
         t.index = IDX_W'(i);
         t.value = v[OUT_BITS-1:0];
         t.last  = (i == n - 1);
         expected_terms.push_back(t);
      end
   endfunction

   // Track settings, predict accepted items, check returned terms
   always @(posedge clock) begin : scoreboard
      basis_term_type got;
      basis_term_type want;
      if (reset) begin
         model_degree = 2'd1;
         model_dims   = DIMS_3D;
      end else begin
         if (csr_we) begin
            if (csr_index == CFG_DEGREE) begin
               model_degree = csr_wdata;
            end else begin
               model_dims = csr_wdata;
            end
         end
         if (req_tvalid && req_tready) begin
            queue_basis(pbg_pkg::cmd_type'(req_tuser[1:0]), req_tuser[3:2],
                        req_tdata[0 +: COORD_BITS], req_tdata[COORD_BITS +: COORD_BITS],
                        req_tdata[2*COORD_BITS +: COORD_BITS], item_check);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.index = rsp_tdata[IDX_W-1:0];
            got.value = rsp_tdata[IDX_W +: OUT_BITS];
            got.last  = rsp_tlast;
            if (expected_terms.size() == 0) begin
               errors++;
               $display("%0t: term with nothing expected: index %0d value %h last %b",
                        $time, got.index, got.value, got.last);
            end else begin
               want = expected_terms.pop_front();
               if (got.index != want.index) begin
                  errors++;
                  $display("%0t: term_index expected %0d actual %0d",
                           $time, want.index, got.index);
               end
               if (got.value != want.value) begin
                  errors++;
                  $display("%0t: term_value (index %0d) expected %h actual %h",
                           $time, want.index, want.value, got.value);
               end
               if (got.last != want.last) begin
                  errors++;
                  $display("%0t: last_term (index %0d) expected %b actual %b",
                           $time, want.index, want.last, got.last);
               end
            end
         end
      end
   end

   // Stall the result side in random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
         if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Present one item and hold it until taken; returns on a falling edge
   task automatic send_item(input pbg_pkg::cmd_type cmd, input logic [1:0] axis,
                            input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic [COORD_BITS-1:0] z, input check_kind_type chk);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tdata  = {z, y, x};
      req_tuser  = {axis, cmd};
      item_check = chk;
      req_tvalid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_tready);
      @(negedge clock);
   endtask

   // Wait for all outstanding terms
   task automatic drain_terms();
      req_tvalid = 1'b0;
      while (expected_terms.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Write both registers once the block is idle
   task automatic write_config(input logic [1:0] degree, input logic [1:0] dims);
      drain_terms();
      csr_we    = 1'b1;
      csr_index = CFG_DEGREE;
      csr_wdata = degree;
      @(negedge clock);
      csr_index = CFG_DIMS;
      csr_wdata = dims;
      @(negedge clock);
      csr_we     = 1'b0;
      cur_degree = degree;
      cur_dims   = dims;
   endtask

   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return POS_MAX;
         1:       return POS_MIN;
         2:       return POS_ZERO;
         default: return COORD_BITS'($urandom());
      endcase
   endfunction

   initial begin
      pbg_pkg::cmd_type cmd;
      logic [1:0]       axis;
      logic [1:0]       degree;
      logic [1:0]       dims;
      int               pick;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed rows, switching settings only where a row asks for it
      foreach (dir_rows[r]) begin
         if (dir_rows[r].degree != cur_degree || dir_rows[r].dims != cur_dims) begin
            write_config(dir_rows[r].degree, dir_rows[r].dims);
         end
         send_item(dir_rows[r].cmd, dir_rows[r].axis, dir_rows[r].x, dir_rows[r].y,
                   dir_rows[r].z, dir_rows[r].chk);
      end

      // Random phases; the middle one and the last one run without gaps
      for (int phase = 0; phase < PHASES; phase++) begin
         degree = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : 2'd3;
         pick   = $urandom_range(0, 5);
         dims   = (pick < 3) ? DIMS_3D : (pick < 5) ? 2'd2 : 2'($urandom_range(0, 1));
         write_config(degree, dims);
         gaps_on = (phase != 2) && (phase != PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 15);
            cmd  = (pick < 5) ? CMD_VALUE : (pick < 10) ? CMD_GRAD :
                   (pick < 15) ? CMD_HESS : CMD_NONE;
            axis = ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
            send_item(cmd, axis, pick_coord(), pick_coord(), pick_coord(), CHK_PREDICT);
         end
      end

      drain_terms();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pbg_pkg.sv
sv/pbg_seq.sv
sv/pbg_mul.sv
sv/polynomial_basis_and_gradient_gen.sv
tb/sv/testbench.sv
